// File: sv/hbir_pkg.sv
package hbir_pkg;

	// Histogram geometry
	localparam int NUM_BINS      = 256;
	localparam int COUNT_BITS    = 24;
	localparam int BIN_ADDR_BITS = $clog2(NUM_BINS);

	// Image geometry and field widths
	localparam int ROWS_BITS = 11;
	localparam int ROW_BITS  = 10;
	localparam int COL_BITS  = 8;
	localparam int CNT_BITS  = 24;
	localparam int PIX_BITS  = 8;

	// Divider sizing: dividend is num_rows * count
	localparam int PROD_BITS    = COUNT_BITS + ROWS_BITS;
	localparam int DIV_CNT_BITS = $clog2(PROD_BITS + 1);

	localparam logic [ROWS_BITS-1:0] NUM_ROWS_RESET = ROWS_BITS'(256);
	localparam logic [PIX_BITS-1:0]  PIXEL_ON       = PIX_BITS'(255);
	localparam logic [PIX_BITS-1:0]  PIXEL_OFF      = '0;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [1:0]          command;
		logic [COL_BITS-1:0] bin_index;
		logic [CNT_BITS-1:0] bin_count;
		logic [ROW_BITS-1:0] row_index;
	} item_t;

	typedef struct packed {
		logic [PIX_BITS-1:0] pixel_value;
		logic                empty_flag;
	} result_t;

endpackage

// File: sv/hbir_ram.sv
module hbir_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: sv/histogram_bar_image_render_unit.sv
// Histogram bar-graph renderer. Load, clear and ignored commands complete in the cycle they
// are accepted, so they can follow each other every cycle. A query passes from acceptance
// through the states ST_READ (bin memory read and num_rows * count multiply), ST_DIV
// (bit-serial restoring divide by the running maximum, one quotient bit per cycle) and
// ST_DONE (form the pixel and register the result). A query on an empty histogram skips
// the divide. The input is not ready while a query is in work; the result sits in an
// output register, and a finished query waits only if that register is still held. The
// bin store is cleared at once by per-bin valid flags, so no clearing pass follows reset
// or a clear command.
module histogram_bar_image_render_unit
	import hbir_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  item_t                item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output result_t              result,
	input  logic                 cfg_we,
	input  logic [ROWS_BITS-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [ROWS_BITS-1:0]    num_rows_q;
	logic [COUNT_BITS-1:0]   max_q;
	logic [NUM_BINS-1:0]     valid_q;
	logic                    in_range_q;
	logic                    row_ok_q;
	logic                    empty_q;
	logic                    hit_q;
	logic [ROW_BITS-1:0]     row_q;
	logic [PROD_BITS-1:0]    quo_q;
	logic [COUNT_BITS-1:0]   rem_q;
	logic [DIV_CNT_BITS-1:0] iter_q;
	logic                    result_valid_q;
	result_t                 result_q;

	logic                     accept;
	logic [31:0]              col_ext;
	logic [31:0]              cnt_ext;
	logic                     col_in_range;
	logic [BIN_ADDR_BITS-1:0] col_addr;
	logic [COUNT_BITS-1:0]    cnt_val;
	logic                     ram_we;
	logic                     ram_re;
	logic [COUNT_BITS-1:0]    rd_data;
	logic [COUNT_BITS-1:0]    bin_val;
	logic [PROD_BITS-1:0]     prod_d;
	logic [COUNT_BITS:0]      trial;
	logic [COUNT_BITS:0]      trial_diff;
	logic                     ge;
	logic [COUNT_BITS-1:0]    rem_next;
	logic [ROWS_BITS-1:0]     k_d;
	logic                     pixel_on;
	logic                     out_free;

	// Decode the request
	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign col_ext      = 32'(item.bin_index);
	assign cnt_ext      = 32'(item.bin_count);
	assign col_in_range = col_ext < 32'(NUM_BINS);
	assign col_addr     = col_ext[BIN_ADDR_BITS-1:0];
	assign cnt_val      = cnt_ext[COUNT_BITS-1:0];
	assign ram_we       = accept && (item.command == CMD_LOAD) && col_in_range;
	assign ram_re       = accept && (item.command == CMD_QUERY);

	hbir_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_BINS)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(col_addr),
		.wdata(cnt_val),
		.re   (ram_re),
		.raddr(col_addr),
		.rdata(rd_data)
	);

	// Bins not written since the last clear read as zero
	assign bin_val = hit_q ? rd_data : '0;
	assign prod_d  = PROD_BITS'(num_rows_q) * PROD_BITS'(bin_val);

	// One restoring divide step: shift in the next dividend bit, subtract if it fits
	assign trial      = {rem_q, quo_q[PROD_BITS-1]};
	assign trial_diff = trial - {1'b0, max_q};
	assign ge         = trial >= {1'b0, max_q};
	assign rem_next   = ge ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];

	// Pixel is inside the bar when the bar height reaches num_rows - row
	assign k_d      = num_rows_q - ROWS_BITS'(row_q);
	assign pixel_on = in_range_q && row_ok_q && (quo_q >= PROD_BITS'(k_d));
	assign out_free = !result_valid_q || result_ready;

	// Sequencer, histogram state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			num_rows_q     <= NUM_ROWS_RESET;
			max_q          <= '0;
			valid_q        <= '0;
			in_range_q     <= 1'b0;
			row_ok_q       <= 1'b0;
			empty_q        <= 1'b0;
			hit_q          <= 1'b0;
			row_q          <= '0;
			quo_q          <= '0;
			rem_q          <= '0;
			iter_q         <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_we) begin
				num_rows_q <= cfg_wdata;
			end
			// Drop the result once taken, unless a new one replaces it this cycle
			if (result_valid_q && result_ready && (state_q != ST_DONE)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.command)
							CMD_LOAD: begin
								if (col_in_range) begin
									valid_q[col_addr] <= 1'b1;
									if (cnt_val > max_q) begin
										max_q <= cnt_val;
									end
								end
							end
							CMD_QUERY: begin
								in_range_q <= col_in_range;
								row_ok_q   <= {1'b0, item.row_index} < num_rows_q;
								row_q      <= item.row_index;
								empty_q    <= (max_q == '0);
								hit_q      <= valid_q[col_addr];
								state_q    <= ST_READ;
							end
							CMD_CLEAR: begin
								valid_q <= '0;
								max_q   <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_READ: begin
					// Load the dividend and start the divide
					quo_q  <= prod_d;
					rem_q  <= '0;
					iter_q <= DIV_CNT_BITS'(PROD_BITS);
					if (empty_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q  <= {quo_q[PROD_BITS-2:0], ge};
					rem_q  <= rem_next;
					iter_q <= iter_q - 1'b1;
					if (iter_q == DIV_CNT_BITS'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// Hold until the output register is free
					if (out_free) begin
						result_valid_q       <= 1'b1;
						result_q.empty_flag  <= empty_q;
						result_q.pixel_value <= (!empty_q && pixel_on) ? PIXEL_ON : PIXEL_OFF;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
